// ===== sv/numeric_literal_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the numeric literal parser
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define NLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nlp assertion failed");
// antecedent implies consequent in the next cycle
`define NLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlp assertion failed");
`else
`define NLP_ASSERT_SAME(lbl, ante, cons)
`define NLP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types, character codes and helpers of the numeric literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

  localparam int MAX_CONSUMED_DEF = 255;
  localparam int CH_W    = 8;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 8;
  localparam int OUT_TDATA_W = 48;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LH     = 8'h68;
  localparam logic [7:0] CH_LX     = 8'h78;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
    logic [CNT_W-1:0]   consumed;
  } nlp_res_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NUL);
  endfunction

  function automatic logic is_h(input logic [7:0] c);
    return (c == CH_LH) || (c == CH_UH);
  endfunction

  // low nibble works for digits; letters a-f / A-F have low nibble 1..6
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    if (is_dec(c)) begin
      d = c[3:0];
    end else begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

// ===== sv/numeric_literal_parser.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_parser
// Streaming parser for one assembler numeric literal per NUL-ended string.
//
//   channel   dir  tdata fields (low bit up)                         tuser
//   in_       in   ch[7:0]                                           -
//   out_      out  value[31:0] status[32] consumed[40:33] pad[47:41] -
//
// One character is taken per cycle while the result register is free, through
// an input register and a result register with the parser state step between
// them. out_tvalid rises once the parse step has loaded the result register
// with the result for the character that ends the number.
// Reset (rst_n low, synchronous) returns to skipping leading white space.
// A stalled output holds its result; the input keeps flowing while the result
// register is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "numeric_literal_parser_macros.svh"

module numeric_literal_parser #(
  parameter int MAX_CONSUMED = nlp_pkg::MAX_CONSUMED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // ch[7:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // value[31:0], status[32], consumed[40:33], zero[47:41]
  output logic [nlp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import nlp_pkg::*;

  logic     ch_valid;
  logic [7:0] ch;
  logic     out_free;
  logic     step;
  logic     emit;
  nlp_res_t res;
  nlp_res_t out_res;

  assign step = ch_valid && out_free;

  nlp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_ch     (in_tdata),
    .take      (out_free),
    .valid     (ch_valid),
    .ch        (ch)
  );

  nlp_parse #(
    .MAX_CONSUMED (MAX_CONSUMED)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (ch),
    .emit  (emit),
    .res   (res)
  );

  nlp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {(OUT_TDATA_W - VALUE_W - 1 - CNT_W)'(0),
                      out_res.consumed, out_res.status, out_res.value};

  `NLP_ASSERT_SAME(a_sink_ready_frees_input, out_tready, in_tready)
  `NLP_ASSERT_NEXT(a_result_needs_char, !out_tvalid && !ch_valid, !out_tvalid)
  `NLP_ASSERT_SAME(a_fail_is_zero, out_tvalid && (out_res.status == STATUS_FAIL), (out_res.value == '0) && (out_res.consumed == '0))
  `NLP_ASSERT_SAME(a_consumed_bound, out_tvalid, 17'(out_res.consumed) <= 17'(MAX_CONSUMED))

endmodule

// ===== sv/nlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// nlp_in_stage
// Input register: holds one character until the parse stage takes it.
// ----------------------------------------------------------------------------
module nlp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_ch,
  input  logic                take,
  output logic                valid,
  output logic [7:0]          ch
);
  import nlp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_ch;
    end
  end

  assign valid = valid_r;
  assign ch    = ch_r;

endmodule

// ===== sv/nlp_parse.sv =====
// ----------------------------------------------------------------------------
// nlp_parse
// Parser state and accumulators; one character is processed per step.
// ----------------------------------------------------------------------------
module nlp_parse #(
  parameter int MAX_CONSUMED = nlp_pkg::MAX_CONSUMED_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  output logic              emit,
  output nlp_pkg::nlp_res_t res
);
  import nlp_pkg::*;

  localparam int IDX_W = $clog2(MAX_CONSUMED + 1);

  typedef enum logic [2:0] {
    PH_SKIP, PH_ZERO, PH_BARE, PH_BAREHEX, PH_PHEX, PH_PBIN, PH_DRAIN
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [VALUE_W-1:0]   hex_r, hex_nxt;
  logic [VALUE_W-1:0]   dec_r, dec_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic                 fire;
  logic                 ok;
  logic [VALUE_W-1:0]   val;
  logic [VALUE_W-1:0]   hex_sh4;
  logic [VALUE_W-1:0]   hex_sh1;
  logic [VALUE_W-1:0]   dec_x10;
  logic [16:0]          idx_wide;

  assign hex_sh4  = (hex_r << 4) + VALUE_W'(hex_digit(ch));
  assign hex_sh1  = (hex_r << 1) + VALUE_W'(ch[0]);
  assign dec_x10  = (dec_r << 3) + (dec_r << 1) + VALUE_W'(ch[3:0]);
  assign idx_wide = 17'(idx_r);

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    dec_nxt   = dec_r;
    idx_nxt   = idx_r;
    fire      = 1'b0;
    ok        = 1'b0;
    val       = '0;

    case (phase_r)
      PH_SKIP: begin
        if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
          phase_nxt = PH_SKIP;
        end else if (ch == CH_DOLLAR) begin
          phase_nxt = PH_PHEX;
        end else if (ch == CH_PCT) begin
          phase_nxt = PH_PBIN;
        end else if (ch == CH_0) begin
          phase_nxt = PH_ZERO;
        end else if (is_dec(ch)) begin
          hex_nxt   = hex_sh4;
          dec_nxt   = dec_x10;
          phase_nxt = PH_BARE;
        end else if (is_hex(ch)) begin
          hex_nxt   = hex_sh4;
          phase_nxt = PH_BAREHEX;
        end else begin
          fire = 1'b1;
        end
      end
      PH_ZERO, PH_BARE: begin
        if ((phase_r == PH_ZERO) && ((ch == CH_LX) || (ch == CH_UX))) begin
          phase_nxt = PH_PHEX;
        end else if ((phase_r == PH_ZERO) && ((ch == CH_LB) || (ch == CH_UB))) begin
          phase_nxt = PH_PBIN;
        end else if (is_dec(ch)) begin
          hex_nxt   = hex_sh4;
          dec_nxt   = dec_x10;
          phase_nxt = PH_BARE;
        end else if (is_hex(ch)) begin
          hex_nxt   = hex_sh4;
          phase_nxt = PH_BAREHEX;
        end else if (is_h(ch)) begin
          fire = 1'b1;
          ok   = 1'b1;
          val  = hex_r;
        end else if (is_term(ch)) begin
          fire = 1'b1;
          ok   = 1'b1;
          val  = dec_r;
        end else begin
          fire = 1'b1;
        end
      end
      PH_BAREHEX: begin
        if (is_hex(ch)) begin
          hex_nxt = hex_sh4;
        end else begin
          fire = 1'b1;
          ok   = is_h(ch) || is_term(ch);
          val  = hex_r;
        end
      end
      PH_PHEX: begin
        if (is_hex(ch)) begin
          hex_nxt = hex_sh4;
        end else begin
          fire = 1'b1;
          ok   = is_term(ch);
          val  = hex_r;
        end
      end
      PH_PBIN: begin
        if ((ch == CH_0) || (ch == CH_1)) begin
          hex_nxt = hex_sh1;
        end else begin
          fire = 1'b1;
          ok   = is_term(ch);
          val  = hex_r;
        end
      end
      PH_DRAIN: begin
        phase_nxt = PH_DRAIN;
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    // count every character taken without a result, outside the drain
    if (!fire && (phase_r != PH_DRAIN) && (idx_r < IDX_W'(MAX_CONSUMED))) begin
      idx_nxt = idx_r + 1'b1;
    end

    if (fire) begin
      phase_nxt = PH_DRAIN;
    end

    // NUL ends the string: rearm for the next one
    if ((ch == CH_NUL) && (fire || (phase_r == PH_DRAIN))) begin
      phase_nxt = PH_SKIP;
      hex_nxt   = '0;
      dec_nxt   = '0;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      hex_r   <= '0;
      dec_r   <= '0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      dec_r   <= dec_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign emit         = fire;
  assign res.value    = ok ? val : '0;
  assign res.status   = ok ? STATUS_OK : STATUS_FAIL;
  assign res.consumed = !ok ? '0 : ((idx_wide > 17'd255) ? 8'hFF : idx_wide[7:0]);

endmodule

// ===== sv/nlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// nlp_out_stage
// Result register: holds one parse result until the sink takes it.
// ----------------------------------------------------------------------------
module nlp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  nlp_pkg::nlp_res_t res,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output nlp_pkg::nlp_res_t out_res
);
  import nlp_pkg::*;

  logic     valid_r, valid_nxt;
  nlp_res_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for numeric_literal_parser. Text is streamed in one
// character per transaction. A local parser tracks each accepted character
// and queues the result that a literal should produce. A monitor compares
// every output transaction field by field with the oldest queued result.
// Directed literals cover each number form, the malformed cases and
// count saturation. A long output stall and a random mix of well-formed,
// corrupted and noise text follow, with random bursts and stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb;
  import nlp_pkg::*;

  typedef logic [7:0] ch_t;

  typedef enum logic [2:0] {
    LIT_SKIP, LIT_ZERO, LIT_BARE, LIT_BAREHEX, LIT_PHEX, LIT_PBIN, LIT_DRAIN
  } lit_phase_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;

  localparam int SAT_COUNT    = MAX_CONSUMED_DEF;
  localparam int ITEM_TARGET  = 1750;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 40;

  localparam string DEC_SET    = "0123456789";
  localparam string HEX_SET    = "0123456789abcdefABCDEF";
  localparam string LETTER_SET = "abcdefABCDEF";
  localparam string BIN_SET    = "01";
  localparam string H_SET      = "hH";

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  numeric_literal_parser #(
    .MAX_CONSUMED(SAT_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Literal parser state and expected results
  // --------------------------------------------------------------------------
  lit_phase_t  lit_phase;
  logic [31:0] acc_hex;
  logic [31:0] acc_dec;
  int unsigned char_count;
  nlp_res_t    pending_results[$];

  int unsigned sent_items   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  function automatic logic in_range(ch_t c, ch_t lo, ch_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic dec_char(ch_t c);
    return in_range(c, CH_0, CH_9);
  endfunction

  function automatic logic hex_char(ch_t c);
    return dec_char(c) || in_range(c, CH_LA, CH_LF) || in_range(c, CH_UA, CH_UF);
  endfunction

  function automatic logic blank_char(ch_t c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic end_char(ch_t c);
    return blank_char(c) || (c == CH_NUL);
  endfunction

  function automatic logic h_char(ch_t c);
    return (c == CH_LH) || (c == CH_UH);
  endfunction

  function automatic logic [3:0] nibble_of(ch_t c);
    if (dec_char(c)) return 4'(c - CH_0);
    if (in_range(c, CH_LA, CH_LF)) return 4'(c - CH_LA + 8'd10);
    return 4'(c - CH_UA + 8'd10);
  endfunction

  function automatic void restart_literal();
    lit_phase  = LIT_SKIP;
    acc_hex    = '0;
    acc_dec    = '0;
    char_count = 0;
  endfunction

  function automatic void finish_literal(ch_t c, logic ok, logic [31:0] val);
    nlp_res_t r;
    r.value    = ok ? val : '0;
    r.status   = ok ? STATUS_OK : STATUS_FAIL;
    r.consumed = ok ? CNT_W'(char_count) : '0;
    pending_results.push_back(r);
    if (c == CH_NUL) restart_literal();
    else lit_phase = LIT_DRAIN;
  endfunction

  // digit run without prefix; returns 1 when the character ends the literal
  function automatic logic take_bare(ch_t c);
    if (dec_char(c)) begin
      acc_hex   = {acc_hex[27:0], nibble_of(c)};
      acc_dec   = acc_dec * 32'd10 + 32'(c - CH_0);
      lit_phase = LIT_BARE;
      return 1'b0;
    end
    if (hex_char(c)) begin
      acc_hex   = {acc_hex[27:0], nibble_of(c)};
      lit_phase = LIT_BAREHEX;
      return 1'b0;
    end
    if (h_char(c)) finish_literal(c, 1'b1, acc_hex);
    else if (end_char(c)) finish_literal(c, 1'b1, acc_dec);
    else finish_literal(c, 1'b0, '0);
    return 1'b1;
  endfunction

  function automatic void predict_char(ch_t c);
    logic done;
    done = 1'b0;
    case (lit_phase)
      LIT_SKIP: begin
        if (!blank_char(c)) begin
          if (c == CH_DOLLAR) lit_phase = LIT_PHEX;
          else if (c == CH_PCT) lit_phase = LIT_PBIN;
          else if (c == CH_0) lit_phase = LIT_ZERO;
          else if (hex_char(c)) done = take_bare(c);
          else begin
            finish_literal(c, 1'b0, '0);
            done = 1'b1;
          end
        end
      end
      LIT_ZERO: begin
        if (c == CH_LX || c == CH_UX) lit_phase = LIT_PHEX;
        else if (c == CH_LB || c == CH_UB) lit_phase = LIT_PBIN;
        else done = take_bare(c);
      end
      LIT_BARE: begin
        done = take_bare(c);
      end
      LIT_BAREHEX: begin
        if (hex_char(c)) acc_hex = {acc_hex[27:0], nibble_of(c)};
        else begin
          finish_literal(c, h_char(c) || end_char(c), acc_hex);
          done = 1'b1;
        end
      end
      LIT_PHEX: begin
        if (hex_char(c)) acc_hex = {acc_hex[27:0], nibble_of(c)};
        else begin
          finish_literal(c, end_char(c), acc_hex);
          done = 1'b1;
        end
      end
      LIT_PBIN: begin
        if (c == CH_0 || c == CH_1) acc_hex = {acc_hex[30:0], c == CH_1};
        else begin
          finish_literal(c, end_char(c), acc_hex);
          done = 1'b1;
        end
      end
      default: begin
        // drop everything up to the NUL; nothing is counted here
        if (c == CH_NUL) restart_literal();
        done = 1'b1;
      end
    endcase
    if (!done && char_count < SAT_COUNT) char_count++;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: bursts of transactions with random gaps
  // --------------------------------------------------------------------------
  ch_t         text_buf[$];
  bit          gaps_on    = 1'b0;
  int unsigned gap_max    = 1;
  int unsigned burst_left = 0;

  function automatic void add_char(ch_t c);
    text_buf.push_back(c);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(ch_t'(s[i]));
  endfunction

  function automatic ch_t pick(string s);
    return ch_t'(s[$urandom_range(s.len() - 1, 0)]);
  endfunction

  task automatic send_char(ch_t c);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat ($urandom_range(gap_max - 1, 0)) @(negedge clk);
      burst_left = $urandom_range(24, 1);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_char(c);
    sent_items++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_buffer();
    while (text_buf.size() > 0) send_char(text_buf.pop_front());
  endtask

  // append s and the NUL to whatever is already buffered, then send it all
  task automatic send_literal(string s);
    add_str(s);
    add_char(CH_NUL);
    send_buffer();
  endtask

  task automatic wait_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall patterns and long holds
  // --------------------------------------------------------------------------
  rdy_mode_t   rdy_mode  = RDY_ALWAYS;
  int unsigned hold_left = 0;
  logic [15:0] stall_pat = 16'hffff;

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        case (rdy_mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_RANDOM: out_tready <= ($urandom_range(99, 0) < 65);
          default: begin
            out_tready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
          end
        endcase
      end
    end
  end

  function automatic void choose_idling();
    case ($urandom_range(3, 0))
      0: begin
        gaps_on  = 1'b0;
        rdy_mode = RDY_ALWAYS;
      end
      1: begin
        gaps_on  = 1'b1;
        gap_max  = $urandom_range(8, 1);
        rdy_mode = RDY_RANDOM;
      end
      2: begin
        gaps_on   = 1'b1;
        gap_max   = 3;
        rdy_mode  = RDY_PATTERN;
        stall_pat = 16'($urandom) | 16'h0001;
      end
      default: begin
        gaps_on   = 1'b0;
        rdy_mode  = RDY_PATTERN;
        stall_pat = 16'($urandom) | 16'h0001;
      end
    endcase
    burst_left = $urandom_range(24, 1);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("tb: result %0d %s: got %0h, expected %0h", results_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    nlp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, value", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("value", out_tdata[31:0], want.value);
        if (out_tdata[32] !== want.status)
          report_mismatch("status", 32'(out_tdata[32]), 32'(want.status));
        if (out_tdata[40:33] !== want.consumed)
          report_mismatch("consumed", 32'(out_tdata[40:33]), 32'(want.consumed));
        if (out_tdata[47:41] !== '0)
          report_mismatch("pad", 32'(out_tdata[47:41]), '0);
      end
    end
  end

  // end the run when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: watchdog, no transaction for %0d cycles", IDLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_random_literal();
    int unsigned len;
    int unsigned ends;
    repeat ($urandom_range(3, 0)) add_char($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
    // mostly short bodies, now and then long enough to wrap
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(7, 0);
    case ($urandom_range(6, 0))
      0: begin
        add_char(pick(DEC_SET));
        repeat (len) add_char(pick(DEC_SET));
      end
      1: begin
        repeat (len) add_char(pick(HEX_SET));
        add_char(pick(LETTER_SET));
        repeat ($urandom_range(3, 0)) add_char(pick(HEX_SET));
      end
      2: begin
        add_char(pick(DEC_SET));
        repeat (len) add_char(pick(DEC_SET));
        add_char(pick(H_SET));
      end
      3: begin
        add_char(CH_DOLLAR);
        repeat (len) add_char(pick(HEX_SET));
      end
      4: begin
        add_char(CH_0);
        add_char($urandom_range(1, 0) ? CH_LX : CH_UX);
        repeat (len) add_char(pick(HEX_SET));
      end
      5: begin
        add_char(CH_PCT);
        repeat (len) add_char(pick(BIN_SET));
      end
      default: begin
        add_char(CH_0);
        add_char($urandom_range(1, 0) ? CH_LB : CH_UB);
        repeat (len) add_char(pick(BIN_SET));
      end
    endcase
    ends = $urandom_range(3, 0);
    if (ends == 1) add_char(CH_SPACE);
    else if (ends == 2) add_char(CH_TAB);
    else if (ends == 3) add_char(pick(H_SET));
    // trailing text that the parser has to skip up to the NUL
    if (ends != 0 && $urandom_range(2, 0) == 0)
      repeat ($urandom_range(6, 1)) add_char(ch_t'($urandom_range(126, 33)));
    add_char(CH_NUL);
  endfunction

  function automatic void corrupt_buffer();
    int unsigned idx;
    ch_t         junk;
    idx  = $urandom_range(text_buf.size() - 2, 0);
    junk = ch_t'($urandom_range(255, 0));
    if ($urandom_range(1, 0)) text_buf[idx] = junk;
    else text_buf.insert(idx, junk);
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(10, 1)) add_char(ch_t'($urandom_range(255, 0)));
    add_char(CH_NUL);
  endfunction

  task automatic test_number_forms();
    gaps_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    send_literal("123");
    send_literal(" \t42 ");
    send_literal("0");
    send_literal("0\t");
    send_literal("0h");
    send_literal("1fh");
    send_literal("ABC");
    send_literal("7Fh");
    send_literal("9H");
    send_literal("$FF");
    send_literal("0x1A");
    send_literal("0XdE ");
    send_literal("%101");
    send_literal("0b11\t");
    send_literal("0B0");
    send_literal("4294967295");
    send_literal("99999999999");
    send_literal("$ffffffff");
    send_literal("$123456789");
    send_literal("123abc");
    send_literal("1Fh trailing");
    send_literal("88 tail");
  endtask

  task automatic test_malformed();
    gaps_on  = 1'b1;
    gap_max  = 4;
    rdy_mode = RDY_RANDOM;
    send_literal("");
    send_literal("   ");
    send_literal("\t");
    send_literal("g1");
    send_literal("h12");
    send_literal("H");
    send_literal("$");
    send_literal("0x");
    send_literal("%");
    send_literal("0b");
    send_literal("$ ");
    send_literal("0X\t");
    send_literal("$1h");
    send_literal("0x2H");
    send_literal("%10h");
    send_literal("%102");
    send_literal("$12g");
    send_literal("12z");
    send_literal("-5");
    add_char(~CH_NUL);
    send_literal("");
    add_char(CH_PCT);
    repeat (40) add_char(CH_1);
    send_literal("");
  endtask

  task automatic test_saturation();
    gaps_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    repeat (254) add_char(CH_TAB);
    send_literal("3");
    repeat (258) add_char(CH_SPACE);
    send_literal("5");
    add_char(CH_DOLLAR);
    repeat (258) add_char(CH_UF);
    send_literal(" ");
  endtask

  // hold the output while literals keep coming, so the input backs up
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    rdy_mode  = RDY_ALWAYS;
    hold_left = HOLD_CYCLES;
    repeat (30) begin
      add_random_literal();
      send_buffer();
    end
    wait_results();
  endtask

  // fill up the run to the item budget with random text
  task automatic test_random_mix();
    int unsigned roll;
    int unsigned next_switch;
    next_switch = sent_items;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= next_switch) begin
        choose_idling();
        next_switch = sent_items + $urandom_range(300, 120);
      end
      roll = $urandom_range(99, 0);
      add_random_literal();
      if (roll < 12) corrupt_buffer();
      else if (roll < 20) begin
        text_buf.delete();
        add_noise();
      end
      send_buffer();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    restart_literal();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_number_forms();
    test_malformed();
    test_saturation();
    wait_results();
    test_backpressure();
    test_random_mix();
    wait_results();

    $display("tb: %0d characters sent, %0d results checked, %0d mismatches",
             sent_items, results_seen, mismatches);
    $display("tb: decimal, bare hex, h suffix, all prefixes, malformed and noisy text,");
    $display("tb: count saturation and a %0d-cycle output hold were exercised", HOLD_CYCLES);
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
